// ===== rtl/u8s_pkg.sv =====
package u8s_pkg;

	localparam logic [7:0] ReplChar   = 8'h3F;
	localparam logic [7:0] AsciiMax   = 8'h7F;
	localparam logic [7:0] Lead2Mask  = 8'hE0;
	localparam logic [7:0] Lead2Code  = 8'hC0;
	localparam logic [7:0] Lead3Mask  = 8'hF0;
	localparam logic [7:0] Lead3Code  = 8'hE0;
	localparam logic [7:0] Lead4Mask  = 8'hF8;
	localparam logic [7:0] Lead4Code  = 8'hF0;
	localparam logic [7:0] ContMask   = 8'hC0;
	localparam logic [7:0] ContCode   = 8'h80;

	localparam int MaxResults = 4;
	localparam int QueueDepth = 4;

	// up to four result bytes produced by one input transaction
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [MaxResults-1:0]      sub;
		logic [2:0]                 count;
		logic                       done;
		logic                       clean;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	// sequence length announced by a lead byte, zero when the byte is no lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & Lead2Mask) == Lead2Code) begin
			len = 3'd2;
		end else if ((b & Lead3Mask) == Lead3Code) begin
			len = 3'd3;
		end else if ((b & Lead4Mask) == Lead4Code) begin
			len = 3'd4;
		end
		return len;
	endfunction

endpackage

// ===== rtl/u8s_front.sv =====
module u8s_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      data_byte,
	input  logic            stream_end,
	input  u8s_pkg::q_stat_t q_stat,
	output logic            push,
	output u8s_pkg::bundle_t push_data
);
	import u8s_pkg::*;

	logic [2:0][7:0] pend_q;
	logic [1:0]      cnt_q;
	logic [2:0]      len_q;
	logic            err_q;

	logic            accept;
	logic            is_cont;
	logic [2:0]      lead;
	bundle_t         bnd;
	logic [2:0]      n;
	logic [1:0]      nxt_cnt;
	logic [2:0]      nxt_len;
	logic            wr_pend;
	logic [1:0]      wr_idx;
	logic            do_fresh;
	logic [1:0]      fresh_pos;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign is_cont  = (data_byte & ContMask) == ContCode;
	assign lead     = lead_len(data_byte);

	always_comb begin
		bnd       = '0;
		n         = 3'd0;
		nxt_cnt   = cnt_q;
		nxt_len   = len_q;
		wr_pend   = 1'b0;
		wr_idx    = 2'd0;
		do_fresh  = 1'b0;
		fresh_pos = 2'd0;

		if (cnt_q != 2'd0) begin
			if (is_cont) begin
				if (({1'b0, cnt_q} + 3'd1) >= len_q) begin
					// sequence complete: release held bytes and this one
					for (int k = 0; k < 3; k++) begin
						if (k < cnt_q) begin
							bnd.bytes[k] = pend_q[k];
						end
					end
					bnd.bytes[cnt_q] = data_byte;
					n       = {1'b0, cnt_q} + 3'd1;
					nxt_cnt = 2'd0;
					nxt_len = 3'd0;
				end else begin
					wr_pend = 1'b1;
					wr_idx  = cnt_q;
					nxt_cnt = cnt_q + 2'd1;
				end
			end else begin
				// broken sequence: replace held bytes, then treat this byte afresh
				for (int k = 0; k < MaxResults; k++) begin
					if (k < cnt_q) begin
						bnd.bytes[k] = ReplChar;
						bnd.sub[k]   = 1'b1;
					end
				end
				n         = {1'b0, cnt_q};
				nxt_cnt   = 2'd0;
				nxt_len   = 3'd0;
				do_fresh  = 1'b1;
				fresh_pos = cnt_q;
			end
		end else begin
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			if (data_byte <= AsciiMax) begin
				bnd.bytes[fresh_pos] = data_byte;
				n = {1'b0, fresh_pos} + 3'd1;
			end else if (lead != 3'd0) begin
				wr_pend = 1'b1;
				wr_idx  = 2'd0;
				nxt_cnt = 2'd1;
				nxt_len = lead;
			end else begin
				bnd.bytes[fresh_pos] = ReplChar;
				bnd.sub[fresh_pos]   = 1'b1;
				n = {1'b0, fresh_pos} + 3'd1;
			end
		end

		if (stream_end) begin
			// flush whatever is still held as replacements
			for (int k = 0; k < MaxResults; k++) begin
				if ((3'(k) >= n) && (3'(k) < (n + {1'b0, nxt_cnt}))) begin
					bnd.bytes[k] = ReplChar;
					bnd.sub[k]   = 1'b1;
				end
			end
			n       = n + {1'b0, nxt_cnt};
			nxt_cnt = 2'd0;
			nxt_len = 3'd0;
		end

		bnd.count = n;
		bnd.done  = stream_end;
		bnd.clean = !(err_q || (|bnd.sub));
	end

	assign push      = accept && (n != 3'd0);
	assign push_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			len_q <= 3'd0;
			err_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= nxt_cnt;
			len_q <= nxt_len;
			err_q <= stream_end ? 1'b0 : (err_q || (|bnd.sub));
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_pend) begin
			pend_q[wr_idx] <= data_byte;
		end
	end

endmodule

// ===== rtl/u8s_queue.sv =====
module u8s_queue #(
	parameter int DEPTH = u8s_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u8s_pkg::bundle_t push_data,
	input  logic             pop,
	output u8s_pkg::bundle_t pop_data,
	output u8s_pkg::q_stat_t q_stat
);
	import u8s_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign q_stat.full  = cnt_q == CW'(DEPTH);
	assign q_stat.avail = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/u8s_back.sv =====
module u8s_back (
	input  logic             clk,
	input  logic             arst_n,
	input  u8s_pkg::q_stat_t q_stat,
	input  u8s_pkg::bundle_t q_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             substituted,
	output logic             run_last,
	output logic             stream_done,
	output logic             stream_valid
);
	import u8s_pkg::*;

	bundle_t    cur_q;
	logic       have_q;
	logic [1:0] idx_q;
	logic       last;
	logic       take;
	logic       load;

	assign last = ({1'b0, idx_q} + 3'd1) == cur_q.count;
	assign take = have_q && !out_stall;
	assign load = !have_q || (take && last);
	assign pop  = load && q_stat.avail;

	assign out_valid    = have_q;
	assign out_byte     = cur_q.bytes[idx_q];
	assign substituted  = cur_q.sub[idx_q];
	assign run_last     = last;
	assign stream_done  = last && cur_q.done;
	assign stream_valid = last && cur_q.done && cur_q.clean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			have_q <= q_stat.avail;
			idx_q  <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// payload of the bundle being played out
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

endmodule

// ===== rtl/utf8_sanitizer.sv =====
// UTF-8 structural sanitiser.
// Input channel: data_byte and stream_end, qualified by in_valid; the block
// holds in_stall high when it cannot take a transaction. Output channel:
// out_byte with substituted, run_last, stream_done and stream_valid,
// qualified by out_valid and held by out_stall from the receiver.
// The front end classifies each byte, holds an open sequence of up to three
// bytes and writes the 0..4 result bytes of that transaction into a
// four-entry queue; the back end plays them out one byte per cycle while
// out_stall is low. The first result of a byte is registered in the queue
// and then in the back end before it shows on out_valid. Throughput: one
// input byte per cycle while each byte yields at most one result; a byte
// with k results takes k output transfers; a full queue raises in_stall.
// stream_done and stream_valid ride on the final result of a stream; all
// stream state is cleared after a byte with stream_end.
// Reset (arst_n low) empties the queue and drops any open sequence.
// A stalled output holds its byte and flags until out_stall falls.
module utf8_sanitizer #(
	parameter int QUEUE_DEPTH = u8s_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       substituted,
	output logic       run_last,
	output logic       stream_done,
	output logic       stream_valid
);
	import u8s_pkg::*;

	q_stat_t q_stat;
	bundle_t push_data;
	bundle_t pop_data;
	logic    push;
	logic    pop;

	u8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.stream_end(stream_end),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	u8s_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	u8s_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.substituted (substituted),
		.run_last    (run_last),
		.stream_done (stream_done),
		.stream_valid(stream_valid)
	);

endmodule

// ===== rtl/u8s_checker.sv =====
module u8s_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       stream_end,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       substituted,
	input logic       run_last,
	input logic       stream_done,
	input logic       stream_valid
);
	import u8s_pkg::*;

	// hold a stalled input transaction until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(stream_end))
		else $error("stalled input transaction changed");

	// a stalled result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(substituted) && $stable(run_last) && $stable(stream_done))
		else $error("stalled result changed");

	a_sub_repl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && substituted |-> out_byte == ReplChar)
		else $error("substituted result is not the replacement character");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> run_last)
		else $error("stream end not on last result of its byte");

	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_valid |-> stream_done && !substituted)
		else $error("clean flag outside a clean stream end");

endmodule

bind utf8_sanitizer u8s_checker u_chk (.*);
